@@ rtl/core/sbm_pkg.sv @@
// Package for the select-below-mean unit: payload structs, sequencer states,
// result kind codes and default sizes. No dependencies.
package sbm_pkg;

  // Default sizes handed to the top level.
  localparam int MAX_ITEMS_DEF  = 16;
  localparam int VALUE_BITS_DEF = 16;

  // Fixed field widths of the channels.
  localparam int VALUE_W     = 16;
  localparam int COUNT_W     = 5;
  localparam int MEAN_W      = 24;
  localparam int FRAC_BITS   = 8;

  localparam logic KIND_VALUE   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last_item;
  } sbm_in_t;

  typedef struct packed {
    logic               kind;
    logic [VALUE_W-1:0] below_value;
    logic [COUNT_W-1:0] below_count;
    logic [MEAN_W-1:0]  mean_fixed;
    logic               overflow;
    logic               last_result;
  } sbm_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_READ,
    ST_TEST,
    ST_SUMMARY
  } sbm_state_t;

endpackage

@@ rtl/core/sbm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module sbm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/sbm_div.sv @@
// Restoring divider, one quotient bit per cycle, for the set mean.
// Standalone; no package dependency.
module sbm_div #(
  parameter int DVD_W = 29,
  parameter int DVS_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int StepW = (DVD_W > 1) ? $clog2(DVD_W) : 1;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [StepW-1:0] step_r, step_nxt;
  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVS_W:0]   trial;
  logic             fits;

  // Shift in the next dividend bit; the remainder stays below the divisor.
  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt  = fits ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
      dvd_nxt  = {dvd_r[DVD_W-2:0], fits};
      step_nxt = step_r + 1'b1;
      if (step_r == StepW'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

@@ rtl/core/select_below_mean_unit.sv @@
// Select-below-mean unit: top level with sequencer, set buffer and output register.
// Depends on sbm_pkg, sbm_ram and sbm_div.
//
// Values are loaded one per cycle into a buffer of MAX_ITEMS entries while a
// running sum and count are kept; values past capacity are dropped and
// flagged. The request carrying last_item closes the set: in_ready then drops
// while the mean is computed and the buffer is walked. The mean comes from a
// restoring divider that makes one quotient bit per cycle. The buffer walk
// reads each stored value from the RAM, then multiplies it by the count and
// compares the product against the sum; the walk and the summary stall while
// a pending result is not taken because out_ready is low. Below-mean values
// come out in arrival order, followed by one summary request.
module select_below_mean_unit #(
  parameter int MAX_ITEMS  = sbm_pkg::MAX_ITEMS_DEF,
  parameter int VALUE_BITS = sbm_pkg::VALUE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  sbm_pkg::sbm_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output sbm_pkg::sbm_out_t out_data
);

  localparam int ValW  = (VALUE_BITS < sbm_pkg::VALUE_W) ? VALUE_BITS : sbm_pkg::VALUE_W;
  localparam int CntW  = $clog2(MAX_ITEMS + 1);
  localparam int AddrW = $clog2(MAX_ITEMS);
  localparam int SumW  = ValW + CntW;
  localparam int DivW  = SumW + sbm_pkg::FRAC_BITS;

  sbm_pkg::sbm_state_t state_r, state_nxt;
  logic [SumW-1:0]     sum_r, sum_nxt;
  logic [CntW-1:0]     count_r, count_nxt;
  logic                drop_r, drop_nxt;
  logic [CntW-1:0]     idx_r, idx_nxt;
  logic [CntW-1:0]     found_r, found_nxt;
  logic                out_valid_r, out_valid_nxt;
  sbm_pkg::sbm_out_t   out_data_r, out_data_nxt;

  logic            accept;
  logic            has_room;
  logic            out_free;
  logic            ram_we;
  logic            ram_re;
  logic [ValW-1:0] rd_data;
  logic [SumW-1:0] prod;
  logic            below;
  logic            div_start;
  logic            div_done;
  logic [DivW-1:0] quot;
  logic [CntW-1:0] idx_inc;

  assign in_ready = (state_r == sbm_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign has_room = count_r < CntW'(MAX_ITEMS);
  assign out_free = !out_valid_r || out_ready;
  assign ram_we   = accept && has_room;
  assign ram_re   = (state_r == sbm_pkg::ST_READ);
  assign div_start = (state_r == sbm_pkg::ST_START);
  assign idx_inc  = idx_r + 1'b1;

  // Exact test against the mean: v * count < sum.
  assign prod  = SumW'(rd_data) * SumW'(count_r);
  assign below = prod < sum_r;

  sbm_ram #(
    .WIDTH (ValW),
    .DEPTH (MAX_ITEMS)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AddrW-1:0]),
    .wdata (in_data.value[ValW-1:0]),
    .re    (ram_re),
    .raddr (idx_r[AddrW-1:0]),
    .rdata (rd_data)
  );

  sbm_div #(
    .DVD_W (DivW),
    .DVS_W (CntW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({sum_r, {sbm_pkg::FRAC_BITS{1'b0}}}),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (quot)
  );

  always_comb begin
    state_nxt     = state_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    drop_nxt      = drop_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      sbm_pkg::ST_IDLE: begin
        if (accept) begin
          if (has_room) begin
            sum_nxt   = sum_r + SumW'(in_data.value[ValW-1:0]);
            count_nxt = count_r + 1'b1;
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_data.last_item) begin
            state_nxt = sbm_pkg::ST_START;
          end
        end
      end
      sbm_pkg::ST_START: begin
        idx_nxt   = '0;
        found_nxt = '0;
        state_nxt = sbm_pkg::ST_DIV;
      end
      sbm_pkg::ST_DIV: begin
        // count is at least one here: a closing request is stored or the buffer is full
        if (div_done) begin
          state_nxt = sbm_pkg::ST_READ;
        end
      end
      sbm_pkg::ST_READ: begin
        state_nxt = sbm_pkg::ST_TEST;
      end
      sbm_pkg::ST_TEST: begin
        // read data holds while stalled, since no new read is issued
        if (!below || out_free) begin
          idx_nxt   = idx_inc;
          state_nxt = (idx_inc == count_r) ? sbm_pkg::ST_SUMMARY : sbm_pkg::ST_READ;
          if (below) begin
            found_nxt                = found_r + 1'b1;
            out_valid_nxt            = 1'b1;
            out_data_nxt.kind        = sbm_pkg::KIND_VALUE;
            out_data_nxt.below_value = sbm_pkg::VALUE_W'(rd_data);
            out_data_nxt.below_count = sbm_pkg::COUNT_W'(found_r + 1'b1);
            out_data_nxt.mean_fixed  = sbm_pkg::MEAN_W'(quot);
            out_data_nxt.overflow    = drop_r;
            out_data_nxt.last_result = 1'b0;
          end
        end
      end
      sbm_pkg::ST_SUMMARY: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.kind        = sbm_pkg::KIND_SUMMARY;
          out_data_nxt.below_value = '0;
          out_data_nxt.below_count = sbm_pkg::COUNT_W'(found_r);
          out_data_nxt.mean_fixed  = sbm_pkg::MEAN_W'(quot);
          out_data_nxt.overflow    = drop_r;
          out_data_nxt.last_result = 1'b1;
          sum_nxt                  = '0;
          count_nxt                = '0;
          drop_nxt                 = 1'b0;
          state_nxt                = sbm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sbm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sbm_pkg::ST_IDLE;
      sum_r       <= '0;
      count_r     <= '0;
      drop_r      <= 1'b0;
      idx_r       <= '0;
      found_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      drop_r      <= drop_nxt;
      idx_r       <= idx_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(MAX_ITEMS))
    else $error("buffer fill count exceeds capacity");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sbm_pkg::ST_READ || state_r == sbm_pkg::ST_TEST) |->
      (found_r <= idx_r && idx_r < count_r))
    else $error("scan index or found count out of range");

  assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == sbm_pkg::ST_DIV)
    else $error("divider finished outside the mean phase");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sbm_pkg::ST_SUMMARY && out_free) |=>
      (state_r == sbm_pkg::ST_IDLE && out_valid_r && out_data_r.last_result
       && count_r == '0 && !drop_r))
    else $error("summary did not close the set");

endmodule
